// File: sv/glzw_pkg.sv
// Shared types, codes and helpers of the GIF LZW encoder.
// No dependencies.
package glzw_pkg;

  localparam int KEY_BITS  = 20;
  localparam int CODE_BITS = 12;
  localparam int ENTRY_BITS = 1 + KEY_BITS + CODE_BITS;
  localparam logic [CODE_BITS-1:0] CODE_LIMIT = 12'd4095;
  localparam logic [3:0] MAX_WIDTH = 4'd12;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_END   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PK_PUT   = 2'd0,
    PK_FLUSH = 2'd1,
    PK_FIN   = 2'd2
  } pk_op_e;

  // command from the sequencer to the bit packer
  typedef struct packed {
    logic                 valid;
    pk_op_e               op;
    logic                 clr;
    logic [CODE_BITS-1:0] code;
    logic [3:0]           width;
  } pk_cmd_t;

  // width after a code has been packed
  function automatic logic [3:0] grow(input logic [3:0] width,
                                      input logic [CODE_BITS-1:0] next_code);
    logic [3:0] res;
    res = width;
    if (width < MAX_WIDTH && {1'b0, next_code} >= (13'd1 << width))
      res = width + 4'd1;
    return res;
  endfunction

endpackage

// File: sv/glzw_if.sv
// Channel interfaces of the GIF LZW encoder: request, byte result, config write.
// Uses nothing else.
interface glzw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] pixel;
  modport source(output valid, req_type, pixel, input ready);
  modport sink(input valid, req_type, pixel, output ready);
endinterface

interface glzw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source(output valid, out_byte, last, input ready);
  modport sink(input valid, out_byte, last, output ready);
endinterface

interface glzw_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] min_code_bits;
  modport source(output valid, min_code_bits, input ready);
  modport sink(input valid, min_code_bits, output ready);
endinterface

// File: sv/glzw_ram.sv
// Single write port, single read port memory with registered read data.
// No dependencies.
module glzw_ram #(
  parameter int ADDR_BITS = 13,
  parameter int DATA_BITS = 33
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/glzw_pack.sv
// Bit packer: accumulates codes LSB first, emits bytes through a hold stage
// and an output register. Depends on glzw_pkg and glzw_if.
module glzw_pack (
  input  logic              clk,
  input  logic              rst,
  input  glzw_pkg::pk_cmd_t cmd,
  output logic              busy,
  glzw_byte_if.source       res
);

  typedef enum logic [2:0] {
    PS_IDLE  = 3'b001,
    PS_DRAIN = 3'b010,
    PS_FIN   = 3'b100
  } pstate_t;

  pstate_t     state;
  logic [23:0] accum;
  logic [4:0]  count;
  logic        flushing;
  logic        hold_v;
  logic [7:0]  hold;
  logic        out_v;
  logic [7:0]  out_b;
  logic        out_l;

  logic        out_free;
  logic        need;
  logic        can_emit;
  logic        out_load;
  logic [23:0] base_acc;
  logic [4:0]  base_cnt;

  assign out_free = !out_v || res.ready;
  assign need     = flushing ? (count != 5'd0) : (count >= 5'd8);
  assign can_emit = !hold_v || out_free;
  assign base_acc = cmd.clr ? 24'd0 : accum;
  assign base_cnt = cmd.clr ? 5'd0 : count;
  assign busy     = (state != PS_IDLE);
  // hold byte moves to the output register this cycle
  assign out_load = hold_v && (((state == PS_DRAIN) && need && out_free) ||
                               ((state == PS_FIN) && out_free));

  assign res.valid    = out_v;
  assign res.out_byte = out_b;
  assign res.last     = out_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= PS_IDLE;
      accum    <= 24'd0;
      count    <= 5'd0;
      flushing <= 1'b0;
      hold_v   <= 1'b0;
      out_v    <= 1'b0;
    end else begin
      if (out_load) begin
        out_v <= 1'b1;
      end else if (out_v && res.ready) begin
        out_v <= 1'b0;
      end
      case (state)
        PS_IDLE: begin
          if (cmd.valid) begin
            case (cmd.op)
              glzw_pkg::PK_PUT: begin
                accum    <= base_acc | ({12'd0, cmd.code} << base_cnt);
                count    <= base_cnt + {1'b0, cmd.width};
                flushing <= 1'b0;
                state    <= PS_DRAIN;
              end
              glzw_pkg::PK_FLUSH: begin
                flushing <= 1'b1;
                state    <= PS_DRAIN;
              end
              glzw_pkg::PK_FIN: begin
                state <= PS_FIN;
              end
              default: begin
                state <= PS_IDLE;
              end
            endcase
          end
        end
        PS_DRAIN: begin
          if (need) begin
            if (can_emit) begin
              if (hold_v) begin
                out_b <= hold;
                out_l <= 1'b0;
              end
              hold   <= accum[7:0];
              hold_v <= 1'b1;
              accum  <= accum >> 8;
              count  <= (count > 5'd8) ? count - 5'd8 : 5'd0;
            end
          end else begin
            if (flushing) begin
              accum <= 24'd0;
              count <= 5'd0;
            end
            state <= PS_IDLE;
          end
        end
        PS_FIN: begin
          // last byte of the item leaves the hold stage marked
          if (!hold_v) begin
            state <= PS_IDLE;
          end else if (out_free) begin
            out_b  <= hold;
            out_l  <= 1'b1;
            hold_v <= 1'b0;
            state  <= PS_IDLE;
          end
        end
        default: begin
          state <= PS_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/gif_lzw_encoder.sv
// GIF LZW encoder top level: request sequencer, hash probe, table clearing.
// Depends on glzw_pkg, glzw_if, glzw_ram and glzw_pack.
//
// Usage:
//   cfg : write min_code_bits (pixel depth, clamped to 2..8) while idle;
//         it is latched by the next start item.
//   req : items of type start (0), pixel (1), end (2); type 3 is dropped.
//   res : raw packed code stream bytes, LSB first; last marks the final
//         byte caused by one item.
// Sequence: one item at a time. A pixel that hits passes a read and a check
// state per hash probe of the dictionary's single read port; a miss adds a
// state that sends the prefix code and writes the new entry, then the finish
// state waits for the packer drain. Start, reset and every table restart
// once the next code reaches 4095 run a clearing pass over all HASH_ENTRIES
// entries during which req is not ready (cfg is always taken).
// Reset: the clearing pass starts right after rst; coding state returns to
// depth 8. A stalled res holds one byte in the output register and one in
// a hold stage; the sequencer waits while both are full.
// HASH_ENTRIES must be a power of two, 4096 to 65536.
module gif_lzw_encoder #(
  parameter int HASH_ENTRIES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  glzw_cfg_if.sink    cfg,
  glzw_req_if.sink    req,
  glzw_byte_if.source res
);

  localparam int HB = $clog2(HASH_ENTRIES);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'h001,
    ST_CLEAR    = 12'h002,
    ST_START_D  = 12'h004,
    ST_START_C  = 12'h008,
    ST_PROBE_RD = 12'h010,
    ST_PROBE_CK = 12'h020,
    ST_MISS     = 12'h040,
    ST_MISS_CLR = 12'h080,
    ST_END_P    = 12'h100,
    ST_END_E    = 12'h200,
    ST_END_F    = 12'h400,
    ST_FIN      = 12'h800
  } state_t;

  state_t      state;
  logic [3:0]  min_code_bits;
  logic [3:0]  depth;
  logic [11:0] prefix_code;
  logic        prefix_valid;
  logic [11:0] next_code;
  logic [3:0]  code_width;
  logic [19:0] key;
  logic [7:0]  px;
  logic [HB-1:0] slot;
  logic [HB-1:0] sweep;

  glzw_pkg::pk_cmd_t cmd;
  logic        pk_busy;

  logic        ram_we;
  logic [HB-1:0] ram_waddr;
  logic [glzw_pkg::ENTRY_BITS-1:0] ram_wdata;
  logic [glzw_pkg::ENTRY_BITS-1:0] ram_rdata;

  logic [3:0]  depth_in;
  logic [7:0]  px_in;
  logic [19:0] key_in;
  logic [19:0] hash_in;
  logic [11:0] clear_code;
  logic        ent_valid;
  logic [19:0] ent_key;
  logic [11:0] ent_code;

  assign depth_in   = (min_code_bits < 4'd2) ? 4'd2 :
                      ((min_code_bits > 4'd8) ? 4'd8 : min_code_bits);
  assign px_in      = req.pixel & 8'((9'd1 << depth) - 9'd1);
  assign key_in     = ({8'd0, prefix_code} << depth) | {12'd0, px_in};
  assign hash_in    = {12'd0, key_in[19:12]} ^ key_in;
  assign clear_code = 12'd1 << depth;
  assign ent_valid  = ram_rdata[glzw_pkg::ENTRY_BITS-1];
  assign ent_key    = ram_rdata[glzw_pkg::ENTRY_BITS-2:glzw_pkg::CODE_BITS];
  assign ent_code   = ram_rdata[glzw_pkg::CODE_BITS-1:0];

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_bits <= 4'd8;
    end else if (cfg.valid) begin
      min_code_bits <= cfg.min_code_bits;
    end
  end

  // packer commands and dictionary writes
  always_comb begin
    cmd       = '0;
    cmd.op    = glzw_pkg::PK_PUT;
    ram_we    = 1'b0;
    ram_waddr = sweep;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_START_D: begin
        cmd.valid = !pk_busy;
        cmd.clr   = 1'b1;
        cmd.code  = {8'd0, depth};
        cmd.width = 4'd8;
      end
      ST_START_C, ST_MISS_CLR: begin
        cmd.valid = !pk_busy;
        cmd.code  = clear_code;
        cmd.width = code_width;
      end
      ST_MISS: begin
        cmd.valid = !pk_busy;
        cmd.code  = prefix_code;
        cmd.width = code_width;
        if (!pk_busy && next_code < glzw_pkg::CODE_LIMIT) begin
          ram_we    = 1'b1;
          ram_waddr = slot;
          ram_wdata = {1'b1, key, next_code};
        end
      end
      ST_END_P: begin
        cmd.valid = !pk_busy && prefix_valid;
        cmd.code  = prefix_code;
        cmd.width = code_width;
      end
      ST_END_E: begin
        cmd.valid = !pk_busy;
        cmd.code  = clear_code + 12'd1;
        cmd.width = code_width;
      end
      ST_END_F: begin
        cmd.valid = !pk_busy;
        cmd.op    = glzw_pkg::PK_FLUSH;
      end
      ST_FIN: begin
        cmd.valid = !pk_busy;
        cmd.op    = glzw_pkg::PK_FIN;
      end
      default: begin
        cmd.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      depth        <= 4'd8;
      prefix_code  <= 12'd0;
      prefix_valid <= 1'b0;
      next_code    <= 12'd258;
      code_width   <= 4'd9;
      sweep        <= '0;
      slot         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            case (req.req_type)
              glzw_pkg::REQ_START: begin
                depth        <= depth_in;
                prefix_code  <= 12'd0;
                prefix_valid <= 1'b0;
                next_code    <= (12'd1 << depth_in) + 12'd2;
                code_width   <= depth_in + 4'd1;
                state        <= ST_START_D;
              end
              glzw_pkg::REQ_PIXEL: begin
                if (!prefix_valid) begin
                  prefix_code  <= {4'd0, px_in};
                  prefix_valid <= 1'b1;
                  state        <= ST_FIN;
                end else begin
                  key   <= key_in;
                  px    <= px_in;
                  slot  <= hash_in[HB-1:0];
                  state <= ST_PROBE_RD;
                end
              end
              glzw_pkg::REQ_END: begin
                state <= ST_END_P;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == {HB{1'b1}}) begin
            state <= ST_FIN;
          end
        end
        ST_START_D: begin
          if (!pk_busy) state <= ST_START_C;
        end
        ST_START_C: begin
          if (!pk_busy) begin
            code_width <= glzw_pkg::grow(code_width, next_code);
            state      <= ST_CLEAR;
          end
        end
        ST_PROBE_RD: begin
          state <= ST_PROBE_CK;
        end
        ST_PROBE_CK: begin
          if (!ent_valid) begin
            state <= ST_MISS;
          end else if (ent_key == key) begin
            prefix_code <= ent_code;
            state       <= ST_FIN;
          end else begin
            slot  <= slot + 1'b1;
            state <= ST_PROBE_RD;
          end
        end
        ST_MISS: begin
          if (!pk_busy) begin
            code_width  <= glzw_pkg::grow(code_width, next_code);
            prefix_code <= {4'd0, px};
            if (next_code >= glzw_pkg::CODE_LIMIT) begin
              state <= ST_MISS_CLR;
            end else begin
              next_code <= next_code + 12'd1;
              state     <= ST_FIN;
            end
          end
        end
        ST_MISS_CLR: begin
          // table restart: width and next code start over
          if (!pk_busy) begin
            next_code  <= clear_code + 12'd2;
            code_width <= depth + 4'd1;
            state      <= ST_CLEAR;
          end
        end
        ST_END_P: begin
          if (!prefix_valid) begin
            state <= ST_END_E;
          end else if (!pk_busy) begin
            code_width <= glzw_pkg::grow(code_width, next_code);
            state      <= ST_END_E;
          end
        end
        ST_END_E: begin
          if (!pk_busy) begin
            code_width <= glzw_pkg::grow(code_width, next_code);
            state      <= ST_END_F;
          end
        end
        ST_END_F: begin
          if (!pk_busy) begin
            prefix_code  <= 12'd0;
            prefix_valid <= 1'b0;
            state        <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!pk_busy) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  glzw_ram #(
    .ADDR_BITS(HB),
    .DATA_BITS(glzw_pkg::ENTRY_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  glzw_pack u_pack (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .busy(pk_busy),
    .res (res)
  );

  assert property (@(posedge clk) disable iff (rst) ram_we |-> !req.ready)
    else $error("dictionary written while taking items");

  assert property (@(posedge clk) !rst && $past(rst) |-> state == ST_CLEAR)
    else $error("no clearing pass after reset");

  assert property (@(posedge clk) disable iff (rst)
                   code_width <= glzw_pkg::MAX_WIDTH && code_width >= 4'd3)
    else $error("code width out of range");

  assert property (@(posedge clk) disable iff (rst)
                   state == ST_PROBE_CK && ent_valid && ent_key == key
                   |=> prefix_code == $past(ent_code))
    else $error("hit did not take the stored code");

  assert property (@(posedge clk) disable iff (rst)
                   cmd.valid |-> !pk_busy)
    else $error("packer command while busy");

endmodule
